// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the GF(2) matrix sampler.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/gf2rim_pkg.sv =====
// Package for the GF(2) invertible matrix sampler: defaults, phase codes,
// and the command and status structs between controller and datapath.
`default_nettype none
package gf2rim_pkg;
    localparam int DEF_MAX_DIM     = 512;
    localparam int DEF_MAX_WORDS   = 8;
    localparam int DEF_BLOCK_BYTES = 256;
    localparam int DIM_W           = 10;
    localparam logic [DIM_W-1:0] DIM_RESET = 10'd128;

    // Matrix phases; the unused code behaves as lower fill.
    localparam logic [1:0] PH_LOWER = 2'd0;
    localparam logic [1:0] PH_UPPER = 2'd1;
    localparam logic [1:0] PH_DROP  = 2'd2;

    // Commands from the controller.
    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [5:0] rd_bit;
        logic       load_out;
        logic       clr_acc;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic is_upper;
        logic row_end;
        logic out_free;
        logic emit_last;
    } t_status;
endpackage
`default_nettype wire

// ===== hw/rtl/gf2rim_ctrl.sv =====
// Controller state machine of the GF(2) matrix sampler: input handshake,
// bit scan over one upper word, and sequencing of row emission. Uses gf2rim_pkg.
`default_nettype none
module gf2rim_ctrl
    import gf2rim_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     s_axis_tvalid,
    output logic    s_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [5:0] r_bit, n_bit;
    logic       r_pend, n_pend;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_cmd.rd_bit = r_bit;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_upper) begin
                        n_state = S_SCAN;
                        n_bit   = 6'd0;
                        n_pend  = i_status.row_end;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'd63) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_pend ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.clr_acc = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= 6'd0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_pend  <= n_pend;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gf2rim_dp.sv =====
// Datapath of the GF(2) matrix sampler: matrix counters, the L row memory,
// the row accumulator and the output register. Uses gf2rim_pkg.
`default_nettype none
module gf2rim_dp
    import gf2rim_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int MAX_WORDS   = DEF_MAX_WORDS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [DIM_W-1:0]  i_cfg_wdata,
    input  wire  [63:0]       s_axis_tdata,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [79:0]       m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);
    localparam int DIM_CAP   = (MAX_DIM < MAX_WORDS * 64) ? MAX_DIM : MAX_WORDS * 64;
    localparam int RB        = $clog2(DIM_CAP);
    localparam int WB        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCB       = $clog2(MAX_WORDS + 1);
    localparam int BLK_WORDS = (BLOCK_BYTES / 8 > 0) ? BLOCK_BYTES / 8 : 1;
    localparam int BKB       = (BLK_WORDS > 1) ? $clog2(BLK_WORDS) : 1;

    logic [DIM_W-1:0] r_matrix_dim, r_active_dim;
    logic [1:0]       r_phase;
    logic [RB-1:0]    r_row;
    logic [WB-1:0]    r_word;
    logic [BKB-1:0]   r_blk;
    logic [MAX_WORDS-1:0][63:0] r_mem [DIM_CAP];
    logic [MAX_WORDS-1:0][63:0] r_acc;
    logic [MAX_WORDS-1:0][63:0] r_rd_row;
    logic             r_rd_v;
    logic [WB-1:0]    r_rd_dw;
    logic [63:0]      r_sel;
    logic [WB-1:0]    r_sel_word;
    logic [WCB-1:0]   r_words;
    logic [WB-1:0]    r_ew;
    logic [8:0]       r_emit_row;
    logic             r_emit_lastm;
    logic [8:0]       r_out_row;
    logic [2:0]       r_out_word;
    logic [63:0]      r_out_data;
    logic             r_out_valid, r_out_last, r_out_lastm;

    logic             first;
    logic [DIM_W-1:0] clamped, dim;
    logic [WCB-1:0]   words;
    logic [BKB-1:0]   blk_nx;
    logic [5:0]       db;
    logic [WB-1:0]    dw;
    logic [DIM_W:0]   rem;
    logic [63:0]      dmask, sel, low_val, x;
    logic [DIM_W:0]   row_p1;
    logic             done_all, row_end;
    logic [RB-1:0]    src;

    assign x = s_axis_tdata;

    // Per-item decode of the current position in the matrix.
    always_comb begin
        first = (r_phase != PH_UPPER) && (r_phase != PH_DROP) &&
                (r_row == '0) && (r_word == '0);
        if (r_matrix_dim == '0) begin
            clamped = DIM_W'(1);
        end else if ({1'b0, r_matrix_dim} > (DIM_W+1)'(DIM_CAP)) begin
            clamped = DIM_W'(DIM_CAP);
        end else begin
            clamped = r_matrix_dim;
        end
        dim    = first ? clamped : r_active_dim;
        words  = WCB'(((DIM_W+1)'(dim) + (DIM_W+1)'(63)) >> 6);
        blk_nx = (r_blk == BKB'(BLK_WORDS - 1)) ? '0 : r_blk + BKB'(1);
        db     = r_row[5:0];
        dw     = WB'(r_row >> 6);
        rem    = (DIM_W+1)'(dim) - (DIM_W+1)'({r_word, 6'b0});
        dmask  = (rem >= (DIM_W+1)'(64)) ? '1 : ((64'd1 << rem[5:0]) - 64'd1);
        sel    = x;
        if (r_word == dw) begin
            sel = (x & ~((64'd2 << db) - 64'd1)) | (64'd1 << db);
        end
        sel      = sel & dmask;
        low_val  = (r_word < dw) ? x : ((x & ((64'd1 << db) - 64'd1)) | (64'd1 << db));
        row_p1   = (DIM_W+1)'(r_row) + (DIM_W+1)'(1);
        done_all = row_p1 >= (DIM_W+1)'(dim);
        row_end  = (WCB'(r_word) + WCB'(1)) >= words;
        src      = RB'({r_sel_word, i_cmd.rd_bit});
    end

    assign o_status.is_upper  = (r_phase == PH_UPPER);
    assign o_status.row_end   = row_end;
    assign o_status.out_free  = !r_out_valid || m_axis_tready;
    assign o_status.emit_last = (WCB'(r_ew) + WCB'(1)) == r_words;

    // Configuration register and matrix counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_dim <= DIM_RESET;
            r_active_dim <= DIM_RESET;
            r_phase      <= PH_LOWER;
            r_row        <= '0;
            r_word       <= '0;
            r_blk        <= '0;
            r_ew         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_matrix_dim <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_ew <= r_ew + WB'(1);
            end
            if (i_cmd.accept) begin
                r_blk <= blk_nx;
                if (first) begin
                    r_active_dim <= clamped;
                end
                case (r_phase)
                    PH_DROP: begin
                        if (blk_nx == '0) begin
                            r_phase <= PH_LOWER;
                        end
                    end
                    PH_UPPER: begin
                        r_ew <= '0;
                        if (row_end) begin
                            if (done_all) begin
                                r_row   <= '0;
                                r_word  <= '0;
                                r_phase <= (blk_nx == '0) ? PH_LOWER : PH_DROP;
                            end else begin
                                r_row  <= RB'(row_p1);
                                r_word <= WB'(row_p1 >> 6);
                            end
                        end else begin
                            r_word <= r_word + WB'(1);
                        end
                    end
                    default: begin
                        if (r_word < dw) begin
                            r_word <= r_word + WB'(1);
                        end else begin
                            r_word <= '0;
                            if (done_all) begin
                                r_row   <= '0;
                                r_phase <= PH_UPPER;
                            end else begin
                                r_row <= RB'(row_p1);
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Upper word capture and emission details for the row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_phase == PH_UPPER) begin
            r_sel      <= sel;
            r_sel_word <= r_word;
            r_words    <= words;
            if (row_end) begin
                r_emit_row   <= 9'(r_row);
                r_emit_lastm <= row_p1 == (DIM_W+1)'(dim);
            end
        end
    end

    // L row memory: one word written per lower item, one row read per cycle of the bit scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_phase != PH_UPPER && r_phase != PH_DROP) begin
            r_mem[r_row][r_word] <= low_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_row <= r_mem[src];
            r_rd_dw  <= r_sel_word;
        end
    end

    // Accumulate the selected L row; words past its diagonal word are zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_rd_v <= i_cmd.rd_en && r_sel[i_cmd.rd_bit];
            if (i_cmd.clr_acc) begin
                r_acc <= '0;
            end else if (r_rd_v) begin
                for (int w = 0; w < MAX_WORDS; w++) begin
                    if (WB'(w) <= r_rd_dw) begin
                        r_acc[w] <= r_acc[w] ^ r_rd_row[w];
                    end
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_row   <= r_emit_row;
            r_out_word  <= 3'(r_ew);
            r_out_data  <= r_acc[r_ew];
            r_out_last  <= o_status.emit_last;
            r_out_lastm <= o_status.emit_last && r_emit_lastm;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data, r_out_word, r_out_row};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_lastm;
endmodule
`default_nettype wire

// ===== hw/rtl/gf2_random_invertible_matrix_sampler_top.sv =====
// Channel     | dir | handshake                   | payload
// s_axis      | in  | s_axis_tvalid/s_axis_tready | tdata: random_word
// m_axis      | out | m_axis_tvalid/m_axis_tready | tdata, tlast, tuser
// cfg         | in  | i_cfg_we                    | i_cfg_wdata: matrix_dim
// Lower-fill and drop items are taken straight from the idle state. An upper item closes
// the input for a scan of its bits, one L row read from the row memory per bit, then
// a drain state. The last upper item of a row then goes on to emit each word of the row.
// Reset is synchronous, active low; the L memory needs no clearing.
// A stalled output holds the block only while emitting a row.
`default_nettype none
`include "assert_macros.svh"
module gf2_random_invertible_matrix_sampler_top
    import gf2rim_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int MAX_WORDS   = DEF_MAX_WORDS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [DIM_W-1:0]  i_cfg_wdata,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  [63:0]       s_axis_tdata,   // [63:0] random_word
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [79:0]       m_axis_tdata,   // [8:0] row_index, [11:9] word_index,
                                              // [75:12] row_word, [79:76] zero
    output logic              m_axis_tlast,   // last_of_row
    output logic              m_axis_tuser    // [0] last_of_matrix
);
    t_cmd    cmd;
    t_status status;

    gf2rim_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    gf2rim_dp #(
        .MAX_DIM     (MAX_DIM),
        .MAX_WORDS   (MAX_WORDS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // An upper item starts a scan, so the input must close next cycle.
    `ASSERT_NEXT(a_upper_blocks, i_clk, i_rst_n, cmd.accept && status.is_upper, !s_axis_tready)
    // The end of a matrix is always the end of a row.
    `ASSERT_IMPL(a_last_nested, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // The output register is loaded only when it is free.
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, cmd.load_out, !m_axis_tvalid || m_axis_tready)
endmodule
`default_nettype wire

// ===== verif/gf2_product_row_checker.sv =====
// Scoreboard for the GF(2) invertible matrix sampler: it watches the random word input,
// the dimension register and the product row output, predicts and compares every item.
// Depends on gf2rim_pkg for the phase codes and the default sizes.
`default_nettype none
module gf2_product_row_checker
    import gf2rim_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [9:0]  i_cfg_wdata,
    input  wire         i_word_valid,
    input  wire         i_word_ready,
    input  wire  [63:0] i_word,
    input  wire         i_row_valid,
    input  wire         i_row_ready,
    input  wire  [79:0] i_row_data,
    input  wire         i_row_last,
    input  wire         i_row_user,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORDS_PER_BLOCK = DEF_BLOCK_BYTES / 8;
    localparam int unsigned DIM_LIMIT       = DEF_MAX_DIM;

    typedef struct packed {
        logic [8:0]  row_index;
        logic [2:0]  word_index;
        logic [63:0] row_word;
        logic        last_of_row;
        logic        last_of_matrix;
    } t_product_word;

    // Predictor state, mirroring the block.
    logic [63:0]   l_rows [0:DIM_LIMIT*8-1];
    logic [63:0]   acc [0:7];
    logic [1:0]    phase_q;
    int unsigned   row_q;
    int unsigned   word_q;
    int unsigned   blk_count;
    logic [9:0]    dim_reg;
    int unsigned   latched_dim;
    t_product_word expected_rows [$];
    int            fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_rows.size();

    // Advance the model by one random word and queue the product words it causes.
    task automatic absorb_word(input logic [63:0] x);
        int unsigned   dim, words, dw, db, src, rem;
        logic [63:0]   sel, mask;
        bit            last_m;
        t_product_word e;
        if (phase_q != PH_UPPER && phase_q != PH_DROP && row_q == 0 && word_q == 0) begin
            if (dim_reg == 0) latched_dim = 1;
            else if (dim_reg > DIM_LIMIT) latched_dim = DIM_LIMIT;
            else latched_dim = dim_reg;
        end
        dim   = latched_dim;
        words = (dim + 63) / 64;
        blk_count = (blk_count + 1) % WORDS_PER_BLOCK;
        if (phase_q == PH_DROP) begin
            if (blk_count == 0) phase_q = PH_LOWER;
            return;
        end
        dw = row_q / 64;
        db = row_q % 64;
        if (phase_q == PH_UPPER) begin
            sel = x;
            if (word_q == dw) begin
                mask = (db >= 63) ? 64'd0 : ~((64'd1 << (db + 1)) - 64'd1);
                sel  = (sel & mask) | (64'd1 << db);
            end
            rem  = dim - word_q * 64;
            mask = (rem >= 64) ? '1 : (64'd1 << rem) - 64'd1;
            sel &= mask;
            for (int i = 0; i < 64; i++) begin
                if (sel[i]) begin
                    src = word_q * 64 + i;
                    for (int w = 0; w < words; w++) acc[w] ^= l_rows[src*8 + w];
                end
            end
            word_q++;
            if (word_q >= words) begin
                last_m = (row_q + 1 == dim);
                for (int w = 0; w < words; w++) begin
                    e.row_index      = row_q[8:0];
                    e.word_index     = w[2:0];
                    e.row_word       = acc[w];
                    e.last_of_row    = (w + 1 == words);
                    e.last_of_matrix = last_m && (w + 1 == words);
                    expected_rows.push_back(e);
                end
                for (int w = 0; w < 8; w++) acc[w] = '0;
                row_q++;
                word_q = row_q / 64;
                if (row_q >= dim) begin
                    row_q   = 0;
                    word_q  = 0;
                    phase_q = (blk_count == 0) ? PH_LOWER : PH_DROP;
                end
            end
            return;
        end
        // Lower fill: full words below the diagonal, then the diagonal word.
        if (word_q < dw) begin
            l_rows[row_q*8 + word_q] = x;
            word_q++;
            return;
        end
        mask = (db == 0) ? 64'd0 : (64'd1 << db) - 64'd1;
        l_rows[row_q*8 + dw] = (x & mask) | (64'd1 << db);
        for (int w = dw + 1; w < 8; w++) l_rows[row_q*8 + w] = '0;
        row_q++;
        word_q = 0;
        if (row_q >= dim) begin
            row_q  = 0;
            word_q = 0;
            for (int w = 0; w < 8; w++) acc[w] = '0;
            phase_q = PH_UPPER;
        end
    endtask

    // Track the register, the input items and the output items at each edge.
    always @(posedge i_clk) begin
        t_product_word e;
        if (!i_rst_n) begin
            for (int w = 0; w < 8; w++) acc[w] = '0;
            phase_q     = PH_LOWER;
            row_q       = 0;
            word_q      = 0;
            blk_count   = 0;
            dim_reg     = DIM_RESET;
            latched_dim = DIM_RESET;
            fails       = 0;
            expected_rows.delete();
        end else begin
            if (i_cfg_we) dim_reg = i_cfg_wdata;
            if (i_word_valid && i_word_ready) absorb_word(i_word);
            if (i_row_valid && i_row_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected output item: tdata %h", i_row_data);
                    fails++;
                end else begin
                    e = expected_rows.pop_front();
                    if (i_row_data[8:0] !== e.row_index) begin
                        $error("row_index: expected %0d, actual %0d", e.row_index,
                               i_row_data[8:0]);
                        fails++;
                    end
                    if (i_row_data[11:9] !== e.word_index) begin
                        $error("word_index: expected %0d, actual %0d", e.word_index,
                               i_row_data[11:9]);
                        fails++;
                    end
                    if (i_row_data[75:12] !== e.row_word) begin
                        $error("row_word: expected %h, actual %h", e.row_word,
                               i_row_data[75:12]);
                        fails++;
                    end
                    if (i_row_last !== e.last_of_row) begin
                        $error("last_of_row: expected %0b, actual %0b", e.last_of_row,
                               i_row_last);
                        fails++;
                    end
                    if (i_row_user !== e.last_of_matrix) begin
                        $error("last_of_matrix: expected %0b, actual %0b", e.last_of_matrix,
                               i_row_user);
                        fails++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_gf2_random_invertible_matrix_sampler_top.sv =====
// Top of the testbench for the GF(2) invertible matrix sampler: clock, reset, stimulus
// of random word streams over several dimensions, and the verdict.
// Depends on gf2rim_pkg, the sampler RTL and gf2_product_row_checker.
`default_nettype none
module tb_gf2_random_invertible_matrix_sampler_top
    import gf2rim_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 2000;
    localparam int SETTLE      = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    gf2_random_invertible_matrix_sampler_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    gf2_product_row_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_word_valid (s_axis_tvalid),
        .i_word_ready (s_axis_tready),
        .i_word       (s_axis_tdata),
        .i_row_valid  (m_axis_tvalid),
        .i_row_ready  (m_axis_tready),
        .i_row_data   (m_axis_tdata),
        .i_row_last   (m_axis_tlast),
        .i_row_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_gf2_random_invertible_matrix_sampler_top: errors");
            $finish;
        end
    end

    // Output side: random stall bursts, and one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one random word and wait until it is taken.
    task automatic send_word(input logic [63:0] w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Wait until every expected item has come, then let trailing drops finish.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Feed one whole matrix plus the words dropped up to the block boundary.
    // A fixed pattern of all ones or all zeros is used when pattern is 1 or 2.
    task automatic run_matrix(input int dim_req, input int pattern);
        int          dim, words, total;
        logic [63:0] w;
        dim   = (dim_req == 0) ? 1 : (dim_req > DEF_MAX_DIM ? DEF_MAX_DIM : dim_req);
        words = (dim + 63) / 64;
        total = 0;
        for (int r = 0; r < dim; r++) total += (r / 64 + 1) + (words - r / 64);
        total += (32 - total % 32) % 32;
        for (int k = 0; k < total; k++) begin
            case (pattern)
                1: w = '1;
                2: w = '0;
                default: begin
                    case ($urandom_range(0, 5))
                        0: w = '0;
                        1: w = '1;
                        2: w = 64'd1 << $urandom_range(0, 63);
                        default: w = {$urandom, $urandom};
                    endcase
                end
            endcase
            send_word(w);
        end
        wait_drained();
    endtask

    task automatic write_dim(input logic [9:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Main sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A matrix ending exactly on a block boundary, under a long output hold-off.
        write_dim(10'd16);
        hold_req = 1'b1;
        run_matrix(16, 0);

        // Two words per row, with the last row alone in its second word.
        write_dim(10'd65);
        run_matrix(65, 0);

        // Final stretch with no idling: zero dimension, fed all ones.
        idle_on = 1'b0;
        write_dim(10'd0);
        run_matrix(0, 1);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_gf2_random_invertible_matrix_sampler_top: clean");
        end else begin
            $display("tb_gf2_random_invertible_matrix_sampler_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== gf2_random_invertible_matrix_sampler_top.f =====
+incdir+hw/rtl
hw/rtl/gf2rim_pkg.sv
hw/rtl/gf2rim_ctrl.sv
hw/rtl/gf2rim_dp.sv
hw/rtl/gf2_random_invertible_matrix_sampler_top.sv
verif/gf2_product_row_checker.sv
verif/tb_gf2_random_invertible_matrix_sampler_top.sv
